// ===== rtl/core/source_text_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_macros
// Assertion macros shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define STT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define STT_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define STT_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, scanner states, widths and the slot type shared by the scanner.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int MAX_TEXT_DEF = 64;
    localparam int POS_BITS_DEF = 16;
    localparam int KIND_W       = 5;
    localparam int LEN_OUT_W    = 7;
    localparam int POS_OUT_W    = 16;
    localparam int ST_W         = 4;

    localparam logic [ST_W-1:0] ST_START = 4'd0;
    localparam logic [ST_W-1:0] ST_INT   = 4'd1;
    localparam logic [ST_W-1:0] ST_FLOAT = 4'd2;
    localparam logic [ST_W-1:0] ST_IDENT = 4'd3;
    localparam logic [ST_W-1:0] ST_STR   = 4'd4;
    localparam logic [ST_W-1:0] ST_ADD   = 4'd5;
    localparam logic [ST_W-1:0] ST_SUB   = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL   = 4'd7;
    localparam logic [ST_W-1:0] ST_DIV   = 4'd8;
    localparam logic [ST_W-1:0] ST_MOD   = 4'd9;
    localparam logic [ST_W-1:0] ST_EQ    = 4'd10;
    localparam logic [ST_W-1:0] ST_LT    = 4'd11;
    localparam logic [ST_W-1:0] ST_GT    = 4'd12;

    localparam logic [KIND_W-1:0] K_END        = 5'd0;
    localparam logic [KIND_W-1:0] K_INT        = 5'd1;
    localparam logic [KIND_W-1:0] K_FLOAT      = 5'd2;
    localparam logic [KIND_W-1:0] K_IDENT      = 5'd3;
    localparam logic [KIND_W-1:0] K_STRING     = 5'd4;
    localparam logic [KIND_W-1:0] K_ADD        = 5'd5;
    localparam logic [KIND_W-1:0] K_SUB        = 5'd7;
    localparam logic [KIND_W-1:0] K_MUL        = 5'd9;
    localparam logic [KIND_W-1:0] K_DIV        = 5'd11;
    localparam logic [KIND_W-1:0] K_MOD        = 5'd13;
    localparam logic [KIND_W-1:0] K_EQ         = 5'd15;
    localparam logic [KIND_W-1:0] K_LT         = 5'd17;
    localparam logic [KIND_W-1:0] K_GT         = 5'd19;
    localparam logic [KIND_W-1:0] K_LPAREN     = 5'd21;
    localparam logic [KIND_W-1:0] K_RPAREN     = 5'd22;
    localparam logic [KIND_W-1:0] K_LBRACK     = 5'd23;
    localparam logic [KIND_W-1:0] K_RBRACK     = 5'd24;
    localparam logic [KIND_W-1:0] K_LBRACE     = 5'd25;
    localparam logic [KIND_W-1:0] K_RBRACE     = 5'd26;
    localparam logic [KIND_W-1:0] K_SEMI       = 5'd27;
    localparam logic [KIND_W-1:0] K_COMMA      = 5'd28;
    localparam logic [KIND_W-1:0] K_BAD_CHAR   = 5'd29;
    localparam logic [KIND_W-1:0] K_BAD_STRING = 5'd30;

    // one result slot
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [POS_OUT_W-1:0] start;
        logic [LEN_OUT_W-1:0] len;
        logic                 flag;
    } tok_t;

    // one classified character: up to two results
    typedef struct packed {
        logic valid0;
        tok_t tok0;
        logic valid1;
        tok_t tok1;
    } tok_pair_t;

    function automatic logic [KIND_W-1:0] op_kind(input logic [ST_W-1:0] st);
        logic [KIND_W-1:0] k;
        k = K_END;
        unique case (st)
            ST_ADD:  k = K_ADD;
            ST_SUB:  k = K_SUB;
            ST_MUL:  k = K_MUL;
            ST_DIV:  k = K_DIV;
            ST_MOD:  k = K_MOD;
            ST_EQ:   k = K_EQ;
            ST_LT:   k = K_LT;
            ST_GT:   k = K_GT;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = K_END;
        unique case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner state machine: classifies one character per cycle unless the queue
// is full, emits up to two finished tokens per character into the queue.
// ----------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       char_code,
    output logic             push,
    output tok_pair_t        push_data,
    input  logic             q_full
);

    localparam int LEN_W = $clog2(MAX_TEXT + 1);
    localparam logic [LEN_W-1:0]    LEN_MAX = LEN_W'(MAX_TEXT);
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [ST_W-1:0]     state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] pstart_reg, pstart_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    logic                povf_reg, povf_next;

    logic [7:0] c;
    logic is_dig, is_alp, is_sp, is_id;
    logic rescan;
    logic [POS_BITS-1:0] pos_a;
    logic [LEN_W-1:0] plen_a;
    logic povf_a;
    logic [KIND_W-1:0] pk;
    logic [POS_BITS-1:0] pos_inc;
    tok_t t_pend, t_new;
    logic v_pend, v_new;
    logic [KIND_W-1:0] pend_kind, new_kind;
    logic acc;
    logic two_res;
    logic tok0_str;
    logic end_at_start;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;
    assign c = char_code;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_sp  = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    assign is_id  = is_alp || is_dig || (c == 8'h5F);
    assign pk = punct_kind(c);

    function automatic logic [POS_BITS-1:0] adv(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + POS_BITS'(1);
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        pos_a       = pos_reg;
        plen_a      = plen_reg;
        povf_a      = povf_reg;
        pstart_next = pstart_reg;
        rescan      = 1'b1;
        v_pend      = 1'b0;
        pend_kind   = K_END;
        // pending-token stage
        unique case (state_reg)
            ST_INT:
            begin
                if (is_dig || c == 8'h2E)
                begin
                    rescan = 1'b0;
                    if (c == 8'h2E)
                        state_next = ST_FLOAT;
                end
                else
                begin
                    v_pend = 1'b1;
                    pend_kind = K_INT;
                end
            end
            ST_FLOAT:
            begin
                if (is_dig)
                    rescan = 1'b0;
                else
                begin
                    v_pend = 1'b1;
                    pend_kind = K_FLOAT;
                end
            end
            ST_IDENT:
            begin
                if (is_id)
                    rescan = 1'b0;
                else
                begin
                    v_pend = 1'b1;
                    pend_kind = K_IDENT;
                end
            end
            ST_STR:
            begin
                if (c == 8'h22)
                begin
                    v_pend = 1'b1;
                    pend_kind = K_STRING;
                    rescan = 1'b0;
                    state_next = ST_START;
                end
                else if (c == 8'h00)
                begin
                    v_pend = 1'b1;
                    pend_kind = K_BAD_STRING;
                end
                else
                    rescan = 1'b0;
            end
            ST_ADD, ST_SUB, ST_MUL, ST_DIV, ST_MOD, ST_EQ, ST_LT, ST_GT:
            begin
                v_pend = 1'b1;
                if (c == 8'h3D)
                begin
                    pend_kind = op_kind(state_reg) + KIND_W'(1);
                    rescan = 1'b0;
                    state_next = ST_START;
                end
                else
                    pend_kind = op_kind(state_reg);
            end
            default: ;
        endcase
        // consumed into the pending token: add char (not for closing quote)
        if (!rescan && !(state_reg == ST_STR && c == 8'h22))
        begin
            if (plen_a < LEN_MAX)
                plen_a = plen_a + LEN_W'(1);
            else
                povf_a = 1'b1;
        end
        t_pend.kind  = pend_kind;
        t_pend.start = POS_OUT_W'(pstart_reg);
        t_pend.len   = LEN_OUT_W'(plen_a);
        t_pend.flag  = povf_a;
        if (!rescan)
            pos_a = adv(pos_reg);

        // start-state stage
        pos_inc = adv(pos_reg);
        v_new   = 1'b0;
        new_kind = K_END;
        plen_next = plen_a;
        povf_next = povf_a;
        pos_next  = pos_a;
        if (rescan)
        begin
            state_next = ST_START;
            pos_next = pos_inc;
            if (is_sp)
                ;
            else if (is_dig || c == 8'h2E || is_alp || c == 8'h5F || c == 8'h22
                     || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F
                     || c == 8'h25 || c == 8'h3D || c == 8'h3C || c == 8'h3E)
            begin
                pstart_next = pos_reg;
                povf_next = 1'b0;
                plen_next = (c == 8'h22) ? '0 : LEN_W'(1);
                priority if (is_dig)                 state_next = ST_INT;
                else if (c == 8'h2E)                 state_next = ST_FLOAT;
                else if (is_alp || c == 8'h5F)       state_next = ST_IDENT;
                else if (c == 8'h22)                 state_next = ST_STR;
                else if (c == 8'h2B)                 state_next = ST_ADD;
                else if (c == 8'h2D)                 state_next = ST_SUB;
                else if (c == 8'h2A)                 state_next = ST_MUL;
                else if (c == 8'h2F)                 state_next = ST_DIV;
                else if (c == 8'h25)                 state_next = ST_MOD;
                else if (c == 8'h3D)                 state_next = ST_EQ;
                else if (c == 8'h3C)                 state_next = ST_LT;
                else                                 state_next = ST_GT;
            end
            else if (pk != K_END)
            begin
                v_new = 1'b1;
                new_kind = pk;
            end
            else if (c == 8'h00)
            begin
                v_new = 1'b1;
                new_kind = K_END;
                pos_next = '0;
            end
            else
            begin
                v_new = 1'b1;
                new_kind = K_BAD_CHAR;
            end
        end
        t_new.kind  = new_kind;
        t_new.start = POS_OUT_W'(pos_reg);
        t_new.len   = (new_kind == K_END) ? '0 : LEN_OUT_W'(1);
        t_new.flag  = 1'b0;
    end

    always_comb
    begin
        push = acc && (v_pend || v_new);
        push_data.valid0 = v_pend ? 1'b1 : v_new;
        push_data.tok0   = v_pend ? t_pend : t_new;
        push_data.valid1 = v_pend && v_new;
        push_data.tok1   = t_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            povf_reg   <= 1'b0;
        end
        else if (acc)
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            povf_reg   <= povf_next;
        end
    end

    assign two_res      = push && push_data.valid1;
    assign tok0_str     = (push_data.tok0.kind == K_STRING);
    assign end_at_start = acc && (c == 8'h00) && (state_reg == ST_START);

`include "source_text_tokenizer_macros.svh"
    `STT_ASSERT_IMPL(a_len_cap, clk, rst_n, 1'b1, plen_reg <= LEN_MAX, "pending length over max")
    `STT_ASSERT_IMPL(a_str_pair, clk, rst_n, two_res, !tok0_str, "string gave two results")
    `STT_ASSERT_NEXT(a_end_pos, clk, rst_n, end_at_start, pos_reg == '0, "position kept at end")

endmodule

// ===== rtl/core/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Two-entry token-pair queue and output sequencer, one token per ready cycle.
// ----------------------------------------------------------------------------
module stt_back
    import stt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tok_pair_t            push_data,
    output logic                 q_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    token_kind,
    output logic [POS_OUT_W-1:0] start_pos,
    output logic [LEN_OUT_W-1:0] text_length,
    output logic                 too_long,
    output logic                 last_of_item
);

    tok_pair_t  mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       half_reg, half_next;
    logic       pop;
    tok_pair_t  head;
    tok_t       cur;

    assign head = mem_reg[rd_reg];
    assign q_full = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign cur = half_reg ? head.tok1 : head.tok0;
    assign token_kind   = cur.kind;
    assign start_pos    = cur.start;
    assign text_length  = cur.len;
    assign too_long     = cur.flag;
    assign last_of_item = half_reg || !head.valid1;
    assign pop = out_valid && out_ready && last_of_item;

    always_comb
    begin
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next   = pop ? !rd_reg : rd_reg;
        wr_next   = push ? !wr_reg : wr_reg;
        half_next = half_reg;
        if (out_valid && out_ready)
            half_next = !last_of_item;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            half_reg <= half_next;
        end
    end

`include "source_text_tokenizer_macros.svh"
    `STT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !q_full || pop, "push into full queue")
    `STT_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count out of range")
    `STT_ASSERT_IMPL(a_half_ok, clk, rst_n, half_reg, out_valid, "second half with empty queue")

endmodule

// ===== rtl/core/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: one character in, tokens with kind/start/length out.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid/in_ready   | char_code
// out     | out_valid/out_ready | token_kind start_pos text_length too_long last_of_item
// One character accepted per cycle while the queue is not full; the state machine
// updates in that cycle. Tokens are registered in the queue before they reach the
// output; a character giving two tokens is delivered as two transfers. A two-entry
// queue decouples the sides: input stalls only when it holds two undelivered characters.
// Reset clears scanner state, position and queue.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           char_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    token_kind,
    output logic [POS_OUT_W-1:0] start_pos,
    output logic [LEN_OUT_W-1:0] text_length,
    output logic                 too_long,
    output logic                 last_of_item
);

    logic      push;
    tok_pair_t push_data;
    logic      q_full;

    stt_front #(.MAX_TEXT(MAX_TEXT), .POS_BITS(POS_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .push(push), .push_data(push_data), .q_full(q_full)
    );

    stt_back u_back
    (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .q_full(q_full),
        .out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
        .start_pos(start_pos), .text_length(text_length), .too_long(too_long),
        .last_of_item(last_of_item)
    );

endmodule
